/* rtl/jss_pkg.sv */
package jss_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  // Wide enough for entry_count, for DEPTH itself and for a block end past the count.
  localparam int CNT_W  = (ADDR_W + 1 > 11) ? ADDR_W + 1 : 11;
  localparam int WORD_W = 32;
  localparam int IDX_W  = 10;
  localparam int POS_W  = 10;
  localparam int EC_W   = 11;
  localparam int JS_W   = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_STEP   = 2'd1;

  typedef struct packed {
    logic                     action;
    logic [IDX_W-1:0]         entry_index;
    logic signed [WORD_W-1:0] entry_value;
    logic signed [WORD_W-1:0] search_key;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } out_item_t;

  typedef struct packed {
    logic [EC_W-1:0] entry_count;
    logic [JS_W-1:0] jump_step;
  } search_cfg_t;

  function automatic logic [CNT_W-1:0] cnt_min(input logic [CNT_W-1:0] a,
                                              input logic [CNT_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

/* rtl/jss_ram.sv */
module jss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/jss_search.sv */
module jss_search
  import jss_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  search_cfg_t              cfg,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_data,
  output logic                     ram_we,
  output logic [ADDR_W-1:0]        ram_waddr,
  output logic [WORD_W-1:0]        ram_wdata,
  output logic [ADDR_W-1:0]        ram_raddr,
  input  logic signed [WORD_W-1:0] ram_rdata
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_JUMP  = 2'd1;
  localparam logic [1:0] ST_LIN   = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  logic [1:0]               state_r, state_nxt;
  logic signed [WORD_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]         n_r, n_nxt;
  logic [CNT_W-1:0]         m_r, m_nxt;
  logic [CNT_W-1:0]         step_r, step_nxt;
  logic [CNT_W-1:0]         prev_r, prev_nxt;
  logic [CNT_W-1:0]         lim_r, lim_nxt;
  logic [ADDR_W-1:0]        addr_r, addr_nxt;
  logic                     out_valid_r;
  out_item_t                out_data_r;

  logic             fin, fin_found;
  logic [POS_W-1:0] fin_pos;
  logic             out_free;
  logic [CNT_W-1:0] ec_ext, n_cfg, m_cfg, step_add, prev_inc;
  logic             key_above;

  assign ec_ext   = CNT_W'(cfg.entry_count);
  assign n_cfg    = (ec_ext > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : ec_ext;
  assign m_cfg    = (cfg.jump_step == '0) ? CNT_W'(1) : CNT_W'(cfg.jump_step);
  assign step_add = step_r + m_r;
  assign prev_inc = prev_r + CNT_W'(1);
  assign key_above = ram_rdata < key_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Writes land only while no search runs, so reads never race a write.
  assign in_stall  = (state_r != ST_IDLE);
  assign ram_we    = in_valid && !in_stall && (in_data.action == ACT_WRITE) &&
                     (CNT_W'(in_data.entry_index) < CNT_W'(DEPTH));
  assign ram_waddr = ADDR_W'(in_data.entry_index);
  assign ram_wdata = in_data.entry_value;
  assign ram_raddr = addr_nxt;

  always_comb begin
    state_nxt = state_r;
    key_nxt   = key_r;
    n_nxt     = n_r;
    m_nxt     = m_r;
    step_nxt  = step_r;
    prev_nxt  = prev_r;
    lim_nxt   = lim_r;
    addr_nxt  = addr_r;
    fin       = 1'b0;
    fin_found = 1'b0;
    fin_pos   = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_data.action == ACT_SEARCH) begin
          key_nxt  = in_data.search_key;
          n_nxt    = n_cfg;
          m_nxt    = m_cfg;
          step_nxt = m_cfg;
          prev_nxt = '0;
          if (n_cfg == '0) begin
            state_nxt = ST_EMPTY;
          end else begin
            state_nxt = ST_JUMP;
            addr_nxt  = ADDR_W'(cnt_min(m_cfg, n_cfg) - CNT_W'(1));
          end
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          fin       = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_JUMP: begin
        if (key_above) begin
          if (step_r >= n_r) begin
            // give up; on a busy output hold and re-read the same word
            if (out_free) begin
              fin       = 1'b1;
              state_nxt = ST_IDLE;
            end
          end else begin
            prev_nxt = step_r;
            step_nxt = step_add;
            addr_nxt = ADDR_W'(cnt_min(step_add, n_r) - CNT_W'(1));
          end
        end else begin
          state_nxt = ST_LIN;
          lim_nxt   = cnt_min(step_r, n_r);
          addr_nxt  = ADDR_W'(prev_r);
        end
      end
      ST_LIN: begin
        if (key_above) begin
          if (prev_inc == lim_r) begin
            if (out_free) begin
              fin       = 1'b1;
              state_nxt = ST_IDLE;
            end
          end else begin
            prev_nxt = prev_inc;
            addr_nxt = ADDR_W'(prev_inc);
          end
        end else if (out_free) begin
          fin       = 1'b1;
          fin_found = (ram_rdata == key_r);
          fin_pos   = fin_found ? POS_W'(prev_r) : '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    n_r    <= n_nxt;
    m_r    <= m_nxt;
    step_r <= step_nxt;
    prev_r <= prev_nxt;
    lim_r  <= lim_nxt;
    addr_r <= addr_nxt;
    if (fin) begin
      out_data_r.found    <= fin_found;
      out_data_r.position <= fin_pos;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_jump_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_JUMP) |-> (step_r == prev_r + m_r))
    else $error("jump block end does not follow block start by one step");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_JUMP || state_r == ST_LIN) |-> (CNT_W'(addr_r) < n_r))
    else $error("search read beyond the searched entries");

  a_lin_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LIN) |-> (prev_r < lim_r && lim_r <= n_r))
    else $error("linear scan left its block");

  a_result_from_search: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) != ST_IDLE))
    else $error("result raised without a search in progress");
`endif

endmodule

/* rtl/jump_search_sorted_table_top.sv */
// Sorted-table jump search. Write items store one signed word into the table and
// give no result; the table holds garbage until written, so software fills every
// searched entry first and needs no clearing pass after reset. A search item with
// n = min(entry_count, DEPTH) and block size m starts in idle, then reads the table
// one word at a time (single read port, registered read data): up to ceil(n/m)
// block-end reads plus up to m reads inside the block, the last word re-read while
// the output is busy. The result register loads once the last word is in and the
// output is free, and the next item is taken in the cycle after; the input stalls
// while a search runs. A finished result waits in its register while the next item
// is taken. Set entry_count and jump_step only while idle.
module jump_search_sorted_table_top
  import jss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  search_cfg_t              cfg_r;
  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr, ram_raddr;
  logic [WORD_W-1:0]        ram_wdata, ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.entry_count <= EC_W'(1);
      cfg_r.jump_step   <= JS_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      // drop writes to unknown indexes
      if (cfg_index == REG_ENTRY_COUNT) begin
        cfg_r.entry_count <= EC_W'(cfg_data);
      end else if (cfg_index == REG_JUMP_STEP) begin
        cfg_r.jump_step <= JS_W'(cfg_data);
      end
    end
  end

  jss_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  jss_search u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

endmodule

/* sim/tb_jump_search_sorted_table_top.sv */
module tb_jump_search_sorted_table_top;
  import jss_pkg::*;

  localparam logic signed [WORD_W-1:0] MIN_WORD = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] MAX_WORD = 32'sh7FFF_FFFF;
  localparam int SETTLE_CYCLES = 80;
  localparam int BIG_N = 160;

  class jump_search_board;
    logic signed [WORD_W-1:0] mirror [DEPTH];
    logic [EC_W-1:0]          count_reg;
    logic [JS_W-1:0]          step_reg;
    out_item_t                expected_answers[$];
    int                       errors;

    function new();
      count_reg = 1;
      step_reg  = 1;
      errors    = 0;
      foreach (mirror[i]) mirror[i] = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ENTRY_COUNT: count_reg = data[EC_W-1:0];
        REG_JUMP_STEP:   step_reg  = data[JS_W-1:0];
        default: ;
      endcase
    endfunction

    function out_item_t predict_lookup(logic signed [WORD_W-1:0] key);
      out_item_t res;
      int n, m, blk_end, prev, hi;
      res = '0;
      n = int'(count_reg);
      if (n > DEPTH) n = DEPTH;
      m = (step_reg == 0) ? 1 : int'(step_reg);
      if (n == 0) return res;
      blk_end = m;
      prev = 0;
      hi = (blk_end < n) ? blk_end : n;
      // jump over whole blocks while the block's last entry is below the key
      while (mirror[hi-1] < key) begin
        prev = blk_end;
        blk_end += m;
        if (prev >= n) return res;
        hi = (blk_end < n) ? blk_end : n;
      end
      while (mirror[prev] < key) begin
        prev++;
        if (prev == hi) return res;
      end
      if (mirror[prev] == key) begin
        res.found    = 1'b1;
        res.position = prev[POS_W-1:0];
      end
      return res;
    endfunction

    function void note_item(in_item_t it);
      if (it.action == ACT_WRITE) mirror[it.entry_index] = it.entry_value;
      else expected_answers.push_back(predict_lookup(it.search_key));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual found=%0b position=%0d",
                 $time, got.found, got.position);
        errors++;
        return;
      end
      want = expected_answers.pop_front();
      if (got.found !== want.found) begin
        $display("%0t: found mismatch, expected %0b, actual %0b", $time, want.found, got.found);
        errors++;
      end
      if (got.position !== want.position) begin
        $display("%0t: position mismatch, expected %0d, actual %0d",
                 $time, want.position, got.position);
        errors++;
      end
    endfunction

    function int pending();
      return expected_answers.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  jump_search_board sb = new();

  logic signed [WORD_W-1:0] fill_val [DEPTH];
  int  burst_left = 0;
  int  stall_left = 0;
  int  stall_pct = 30;
  logic calm = 1'b0;
  int  random_searches = 0;

  jump_search_sorted_table_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // receiver: runs of stall or no stall of random length
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_left <= $urandom_range(1, 12);
      out_stall  <= !calm && ($urandom_range(0, 99) < stall_pct);
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.note_item(in_data);
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
    end
  end

  function automatic int isqrt(int n);
    int r;
    r = 0;
    while ((r + 1) * (r + 1) <= n) r++;
    return r;
  endfunction

  function automatic in_item_t make_write(int idx, logic signed [WORD_W-1:0] val);
    in_item_t it;
    it.action      = ACT_WRITE;
    it.entry_index = idx[IDX_W-1:0];
    it.entry_value = val;
    it.search_key  = $urandom();
    return it;
  endfunction

  function automatic in_item_t make_search(logic signed [WORD_W-1:0] key);
    in_item_t it;
    it.action      = ACT_SEARCH;
    it.entry_index = IDX_W'($urandom_range(0, DEPTH - 1));
    it.entry_value = $urandom();
    it.search_key  = key;
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 6);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_key(int n);
    logic signed [WORD_W-1:0] v;
    int r;
    v = fill_val[$urandom_range(0, n - 1)];
    r = $urandom_range(0, 9);
    if (r == 6) v = v + 32'sd1;
    else if (r == 7) v = v - 32'sd1;
    else if (r == 8) v = $urandom_range(0, 1) ? MIN_WORD : MAX_WORD;
    else if (r == 9) v = $urandom();
    return v;
  endfunction

  task automatic drive_item(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = pick_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drop valid and let every answer drain before touching the registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input int count, input int step);
    logic [CFG_DATA_W-1:0] cnt_word, step_word;
    cnt_word  = count[CFG_DATA_W-1:0];
    // upper bits of the step word are ignored by the block
    step_word = {5'($urandom_range(0, 31)), step[JS_W-1:0]};
    wait_idle();
    write_reg(REG_ENTRY_COUNT, cnt_word);
    write_reg(REG_JUMP_STEP, step_word);
    cfg_valid <= 1'b0;
  endtask

  task automatic fill_table(input int n, input int mode);
    longint      cur;
    int unsigned maxinc;
    maxinc = 32'hFFFF_FFFF / n;
    if (mode == 0) cur = -64'sd2147483648 + longint'($urandom_range(0, maxinc));
    else cur = longint'($urandom_range(0, 2000)) - 1000;
    for (int i = 0; i < n; i++) begin
      if (mode == 2) fill_val[i] = $urandom();
      else fill_val[i] = cur[WORD_W-1:0];
      drive_item(make_write(i, fill_val[i]));
      if (mode == 0) cur += longint'($urandom_range(0, maxinc));
      else cur += longint'($urandom_range(0, 3));
    end
  endtask

  task automatic run_searches(input int n, input int k);
    int idx;
    for (int s = 0; s < k; s++) begin
      // stray write now and then
      if ($urandom_range(0, 11) == 0) begin
        idx = $urandom_range(0, DEPTH - 1);
        fill_val[idx] = $urandom();
        drive_item(make_write(idx, fill_val[idx]));
      end
      drive_item(make_search(pick_key(n)));
    end
  endtask

  task automatic directed_items();
    // single entry with reset settings
    drive_item(make_write(0, MIN_WORD));
    drive_item(make_search(MIN_WORD));
    drive_item(make_search(MAX_WORD));
    drive_item(make_search(32'sd0));
    // empty table, zero step, writes to unused register indexes
    configure(0, 0);
    write_reg(2'd2, 11'h7FF);
    write_reg(2'd3, 11'h7FF);
    cfg_valid <= 1'b0;
    drive_item(make_search(MIN_WORD));
    configure(4, 0);
    fill_val[0] = MIN_WORD;
    fill_val[1] = -32'sd5;
    fill_val[2] = 32'sd100;
    fill_val[3] = MAX_WORD;
    for (int i = 0; i < 4; i++) drive_item(make_write(i, fill_val[i]));
    drive_item(make_search(MAX_WORD));
    drive_item(make_search(-32'sd5));
    drive_item(make_search(32'sd7));
    configure(4, 2);
    drive_item(make_search(MIN_WORD));
    drive_item(make_search(32'sd100));
    drive_item(make_search(MAX_WORD));
    drive_item(make_search(32'sd101));
    // break the order: the scan stops early and misses a present key
    fill_val[1] = 32'sd500;
    drive_item(make_write(1, fill_val[1]));
    drive_item(make_search(32'sd100));
    drive_item(make_search(32'sd500));
  endtask

  initial begin
    int n, step, mode;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    directed_items();

    // sorted mid-size table; a saturated count with keys that stay in the first block
    configure(BIG_N, 12);
    fill_table(BIG_N, 0);
    calm <= 1'b1;
    configure(2047, 63);
    drive_item(make_search(MIN_WORD));
    for (int i = 0; i < 63; i += 31) drive_item(make_search(fill_val[i]));
    calm <= 1'b0;
    configure(BIG_N, 12);
    run_searches(BIG_N, 20);
    configure(BIG_N, 1);
    run_searches(BIG_N, 3);
    configure(BIG_N - 1, 31);
    run_searches(BIG_N - 1, 10);

    while (random_searches < 80) begin
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
      step = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : isqrt(n);
      mode = $urandom_range(0, 7);
      mode = (mode == 0) ? 2 : (mode < 3) ? 1 : 0;
      calm      <= ($urandom_range(0, 3) == 0);
      stall_pct <= $urandom_range(10, 60);
      configure(n, step);
      fill_table(n, mode);
      step = $urandom_range(8, 20);
      run_searches(n, step);
      random_searches += step;
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* files.f */
rtl/jss_pkg.sv
rtl/jss_ram.sv
rtl/jss_search.sv
rtl/jump_search_sorted_table_top.sv
sim/tb_jump_search_sorted_table_top.sv
